[hdl/pidail_pkg.sv]
// shared types and constants for the pid controller with adaptive integral limit
package pidail_pkg;

    localparam int DATA_W  = 32;
    localparam int LIMIT_W = 31;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    // register index, byte address is 4 times the index
    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_OUTPUT_LIMIT  = 3'd3,
        REG_LIMIT_GAIN    = 3'd4,
        REG_VELOCITY_MODE = 3'd5,
        REG_ENABLE        = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] prop_gain;
        logic signed [DATA_W-1:0] integ_gain;
        logic signed [DATA_W-1:0] deriv_gain;
        logic        [LIMIT_W-1:0] output_limit;
        logic signed [DATA_W-1:0] limit_gain;
        logic                      velocity_mode;
        logic                      enable;
    } t_cfg;

endpackage

[hdl/pidail_regs.sv]
// apb register file holding the controller gains, limits and mode bits
module pidail_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pidail_pkg::ADDR_W-1:0]  paddr,
    input  logic [pidail_pkg::DATA_W-1:0]  pwdata,
    output logic [pidail_pkg::DATA_W-1:0]  prdata,
    output logic                           pready,
    output pidail_pkg::t_cfg               o_cfg
);
    import pidail_pkg::*;

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // everything clear except enable, which comes up set
            r_cfg <= '{enable: 1'b1, default: '0};
        end else if (wr_en) begin
            case (idx)
                REG_PROP_GAIN:     r_cfg.prop_gain     <= pwdata;
                REG_INTEG_GAIN:    r_cfg.integ_gain    <= pwdata;
                REG_DERIV_GAIN:    r_cfg.deriv_gain    <= pwdata;
                REG_OUTPUT_LIMIT:  r_cfg.output_limit  <= pwdata[LIMIT_W-1:0];
                REG_LIMIT_GAIN:    r_cfg.limit_gain    <= pwdata;
                REG_VELOCITY_MODE: r_cfg.velocity_mode <= pwdata[0];
                REG_ENABLE:        r_cfg.enable        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PROP_GAIN:     prdata = r_cfg.prop_gain;
            REG_INTEG_GAIN:    prdata = r_cfg.integ_gain;
            REG_DERIV_GAIN:    prdata = r_cfg.deriv_gain;
            REG_OUTPUT_LIMIT:  prdata = {1'b0, r_cfg.output_limit};
            REG_LIMIT_GAIN:    prdata = r_cfg.limit_gain;
            REG_VELOCITY_MODE: prdata = {{(DATA_W-1){1'b0}}, r_cfg.velocity_mode};
            REG_ENABLE:        prdata = {{(DATA_W-1){1'b0}}, r_cfg.enable};
            default:           prdata = '0;
        endcase
    end

endmodule

[hdl/pidail_qsat.sv]
// fixed point rescale of a product: floor shift by the fraction bits, then saturate to 32 bits
module pidail_qsat #(
    parameter int IN_W      = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic signed [IN_W-1:0]               i_prod,
    output logic signed [pidail_pkg::DATA_W-1:0] o_val
);
    import pidail_pkg::*;

    logic signed [IN_W-1:0] shifted;
    logic                   ovf;

    // arithmetic shift rounds toward minus infinity
    assign shifted = i_prod >>> FRAC_BITS;
    assign ovf     = !((&shifted[IN_W-1:DATA_W-1]) || !(|shifted[IN_W-1:DATA_W-1]));

    always_comb begin
        if (!ovf) begin
            o_val = shifted[DATA_W-1:0];
        end else if (shifted[IN_W-1]) begin
            o_val = S32_MIN;
        end else begin
            o_val = S32_MAX;
        end
    end

endmodule

[hdl/pidail_datapath.sv]
// seven stage pid pipeline with per-stage flow control and the integral / last error state
module pidail_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pidail_pkg::t_cfg                     i_cfg,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [pidail_pkg::DATA_W-1:0] i_setpoint,
    input  logic signed [pidail_pkg::DATA_W-1:0] i_measured,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [pidail_pkg::DATA_W-1:0] o_drive
);
    import pidail_pkg::*;

    localparam int NSTG = 7;
    localparam int PW   = 2 * DATA_W;
    localparam longint unsigned SEVEN_RAW = ((64'd7 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic signed [DATA_W:0] Q_SEVEN_TENTHS = (DATA_W+1)'(SEVEN_RAW);

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] res;
        if (v[DATA_W] == v[DATA_W-1]) begin
            res = v[DATA_W-1:0];
        end else if (v[DATA_W]) begin
            res = S32_MIN;
        end else begin
            res = S32_MAX;
        end
        return res;
    endfunction

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    // stage can load when empty or when it hands its beat on
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // gains as plain signed operands
    logic signed [DATA_W-1:0] kp, ki, kd, kl;
    assign kp = i_cfg.prop_gain;
    assign ki = i_cfg.integ_gain;
    assign kd = i_cfg.deriv_gain;
    assign kl = i_cfg.limit_gain;

    // stage 0: input register
    logic signed [DATA_W-1:0] r0_sp, r0_meas;
    always_ff @(posedge i_clk) begin
        if (adv[0] && i_in_valid) begin
            r0_sp   <= i_setpoint;
            r0_meas <= i_measured;
        end
    end

    // stage 1: saturated error and bound scale source
    logic signed [DATA_W:0]   err_wide;
    logic signed [DATA_W-1:0] n1_err;
    logic signed [DATA_W-1:0] r1_err, r1_x;
    assign err_wide = {r0_sp[DATA_W-1], r0_sp} - {r0_meas[DATA_W-1], r0_meas};
    assign n1_err   = sat33(err_wide);

    always_ff @(posedge i_clk) begin
        if (adv[1] && r_vld[0]) begin
            r1_err <= n1_err;
            r1_x   <= i_cfg.velocity_mode ? r0_sp : n1_err;
        end
    end

    // stage 2: error difference against the previous sample, full 33 bits
    logic signed [DATA_W-1:0] r_prev_err;
    logic signed [DATA_W-1:0] r2_err, r2_x;
    logic signed [DATA_W:0]   r2_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (adv[2] && r_vld[1]) begin
            r_prev_err <= r1_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2] && r_vld[1]) begin
            r2_err  <= r1_err;
            r2_x    <= r1_x;
            r2_diff <= {r1_err[DATA_W-1], r1_err} - {r_prev_err[DATA_W-1], r_prev_err};
        end
    end

    // stage 3: the four products
    logic signed [PW-1:0] pp_c, ip_c, lp_c;
    logic signed [PW:0]   dp_c;
    logic signed [PW-1:0] r3_pp, r3_ip, r3_lp;
    logic signed [PW:0]   r3_dp;
    assign pp_c = r2_err * kp;
    assign ip_c = r2_err * ki;
    assign lp_c = r2_x * kl;
    assign dp_c = r2_diff * kd;

    always_ff @(posedge i_clk) begin
        if (adv[3] && r_vld[2]) begin
            r3_pp <= pp_c;
            r3_ip <= ip_c;
            r3_lp <= lp_c;
            r3_dp <= dp_c;
        end
    end

    // stage 4: rescale and integral bound
    logic signed [DATA_W-1:0] p_q, i_q, l_q, d_q;
    logic signed [DATA_W:0]   l_abs;
    logic signed [DATA_W-1:0] n4_bound;

    pidail_qsat #(.IN_W(PW),   .FRAC_BITS(FRAC_BITS)) u_qs_p (.i_prod(r3_pp), .o_val(p_q));
    pidail_qsat #(.IN_W(PW),   .FRAC_BITS(FRAC_BITS)) u_qs_i (.i_prod(r3_ip), .o_val(i_q));
    pidail_qsat #(.IN_W(PW),   .FRAC_BITS(FRAC_BITS)) u_qs_l (.i_prod(r3_lp), .o_val(l_q));
    pidail_qsat #(.IN_W(PW+1), .FRAC_BITS(FRAC_BITS)) u_qs_d (.i_prod(r3_dp), .o_val(d_q));

    always_comb begin
        if (l_q[DATA_W-1]) begin
            l_abs = -{l_q[DATA_W-1], l_q};
        end else begin
            l_abs = {l_q[DATA_W-1], l_q};
        end
        if (l_abs > Q_SEVEN_TENTHS) begin
            n4_bound = Q_SEVEN_TENTHS[DATA_W-1:0];
        end else begin
            n4_bound = l_abs[DATA_W-1:0];
        end
    end

    logic signed [DATA_W-1:0] r4_p, r4_i, r4_d, r4_bound;
    always_ff @(posedge i_clk) begin
        if (adv[4] && r_vld[3]) begin
            r4_p     <= p_q;
            r4_i     <= i_q;
            r4_d     <= d_q;
            r4_bound <= n4_bound;
        end
    end

    // stage 5: integral accumulate, saturate, clamp to the bound
    logic signed [DATA_W-1:0] r_integ;
    logic signed [DATA_W-1:0] integ_sat, n_integ;
    logic signed [DATA_W:0]   bnd_pos, bnd_neg, integ_wide;

    assign integ_sat = sat33({r_integ[DATA_W-1], r_integ} + {r4_i[DATA_W-1], r4_i});
    assign bnd_pos   = {r4_bound[DATA_W-1], r4_bound};
    assign bnd_neg   = -bnd_pos;
    assign integ_wide = {integ_sat[DATA_W-1], integ_sat};

    always_comb begin
        if (integ_wide > bnd_pos) begin
            n_integ = bnd_pos[DATA_W-1:0];
        end else if (integ_wide < bnd_neg) begin
            n_integ = bnd_neg[DATA_W-1:0];
        end else begin
            n_integ = integ_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (adv[5] && r_vld[4]) begin
            r_integ <= n_integ;
        end
    end

    logic signed [DATA_W-1:0] r5_p, r5_i, r5_d;
    always_ff @(posedge i_clk) begin
        if (adv[5] && r_vld[4]) begin
            r5_p <= r4_p;
            r5_i <= n_integ;
            r5_d <= r4_d;
        end
    end

    // stage 6: output sum, output clamp, enable gate
    logic signed [DATA_W+1:0] total, lim_pos, lim_neg;
    logic signed [DATA_W-1:0] n6_drive;

    assign total   = {{2{r5_p[DATA_W-1]}}, r5_p} + {{2{r5_i[DATA_W-1]}}, r5_i}
                   + {{2{r5_d[DATA_W-1]}}, r5_d};
    assign lim_pos = {3'b000, i_cfg.output_limit};
    assign lim_neg = -lim_pos;

    always_comb begin
        if (!i_cfg.enable) begin
            n6_drive = '0;
        end else if (total > lim_pos) begin
            n6_drive = lim_pos[DATA_W-1:0];
        end else if (total < lim_neg) begin
            n6_drive = lim_neg[DATA_W-1:0];
        end else begin
            n6_drive = total[DATA_W-1:0];
        end
    end

    logic signed [DATA_W-1:0] r6_drive;
    always_ff @(posedge i_clk) begin
        if (adv[6] && r_vld[5]) begin
            r6_drive <= n6_drive;
        end
    end

    assign o_drive = r6_drive;

endmodule

[hdl/pid_with_adaptive_integral_limit_core.sv]
// top level of the positional pid controller with adaptive integral limit
// usage:
//   s_axis carries one sample per beat: setpoint and measured, signed fixed
//   point with FRAC_BITS fraction bits. m_axis returns one drive value per
//   sample, in sample order. the apb port writes and reads the gains, the
//   output limit, the integral bound scale, velocity mode and enable; write
//   it only while no samples are in flight.
// pipeline and throughput:
//   seven registers (input, error, error difference, multiply, rescale and
//   bound, integral update, output clamp) lie between s_axis and m_axis.
//   one sample per cycle is taken in steady state while m_axis_tready is
//   high; the integral is updated in a single stage so consecutive samples
//   never wait on each other.
// reset:
//   synchronous active low reset empties the pipeline, zeroes the integral
//   and the previous error, zeroes all configuration registers except enable,
//   which comes up set.
// stall:
//   when m_axis_tready is low the result holds on m_axis; each stage
//   stalls only if it and everything after it is full, so bubbles are
//   squeezed out and s_axis_tready drops only when the pipeline is full.
module pid_with_adaptive_integral_limit_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // sample beat
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [2*pidail_pkg::DATA_W-1:0]        s_axis_tdata,  // setpoint [31:0], measured [63:32]
    // result beat
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [pidail_pkg::DATA_W-1:0]          m_axis_tdata,  // drive [31:0]
    // register port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pidail_pkg::ADDR_W-1:0]          paddr,
    input  logic [pidail_pkg::DATA_W-1:0]          pwdata,
    output logic [pidail_pkg::DATA_W-1:0]          prdata,
    output logic                                   pready
);
    import pidail_pkg::*;

    t_cfg                     cfg;
    logic signed [DATA_W-1:0] setpoint, measured, drive;

    // unpack the sample beat
    assign setpoint = s_axis_tdata[DATA_W-1:0];
    assign measured = s_axis_tdata[2*DATA_W-1:DATA_W];

    pidail_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pidail_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_setpoint  (setpoint),
        .i_measured  (measured),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_drive     (drive)
    );

    assign m_axis_tdata = drive;

endmodule

[hdl/pidail_checker.sv]
// port level checks for the pid controller top, attached by bind
module pidail_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [pidail_pkg::DATA_W-1:0]          m_axis_tdata
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // an empty output means nothing can block the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

    // with the sink ready and no reset in between, an accepted sample reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(s_axis_tvalid && s_axis_tready, 7)
         && $past(m_axis_tready, 1) && $past(m_axis_tready, 2) && $past(m_axis_tready, 3)
         && $past(m_axis_tready, 4) && $past(m_axis_tready, 5) && $past(m_axis_tready, 6)
         && $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
         && $past(i_rst_n, 4) && $past(i_rst_n, 5) && $past(i_rst_n, 6)
         && $past(i_rst_n, 7))
        |-> m_axis_tvalid)
        else $error("result beat missing after pipeline latency");

endmodule

bind pid_with_adaptive_integral_limit_core pidail_checker u_pidail_checker (.*);

[test/pidail_drive_checker.sv]
// checker for the pid core: tracks register writes, predicts each drive beat and compares
module pidail_drive_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [2*pidail_pkg::DATA_W-1:0]   i_s_tdata,   // setpoint [31:0], measured [63:32]
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [pidail_pkg::DATA_W-1:0]     i_m_tdata,   // drive [31:0]
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [pidail_pkg::ADDR_W-1:0]     i_paddr,
    input  logic [pidail_pkg::DATA_W-1:0]     i_pwdata,
    input  logic [pidail_pkg::DATA_W-1:0]     i_prdata,
    input  logic                              i_pready,
    output int                                o_pending,
    output int                                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import pidail_pkg::*;

    localparam longint SEVEN_TENTHS = ((64'd7 << FRAC_BITS) + 64'd5) / 64'd10;

    // shadow of the register file
    logic signed [DATA_W-1:0]  kp;
    logic signed [DATA_W-1:0]  ki;
    logic signed [DATA_W-1:0]  kd;
    logic        [LIMIT_W-1:0] drive_limit;
    logic signed [DATA_W-1:0]  bound_scale;
    logic                      by_setpoint;
    logic                      drive_on;

    // controller state
    logic signed [DATA_W-1:0]  integ_acc;
    logic signed [DATA_W-1:0]  last_err;

    logic signed [DATA_W-1:0]  expected_drive[$];

    function automatic logic signed [DATA_W-1:0] clip_word(input logic signed [65:0] v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v[DATA_W-1:0];
    endfunction

    // gain times value, floor shift by the fraction bits, saturated
    function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] gain,
                                                        input logic signed [DATA_W:0]   val);
        logic signed [65:0] prod;
        prod = gain * val;
        return clip_word(prod >>> FRAC_BITS);
    endfunction

    function automatic logic signed [DATA_W-1:0] next_drive(input logic signed [DATA_W-1:0] sp,
                                                            input logic signed [DATA_W-1:0] meas);
        logic signed [DATA_W:0]   err_wide;
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] p_term;
        logic signed [DATA_W-1:0] d_term;
        logic signed [DATA_W:0]   err_step;
        logic signed [65:0]       acc;
        logic signed [33:0]       bound;
        logic signed [34:0]       total;
        logic signed [34:0]       lim;
        err_wide = sp - meas;
        err      = clip_word(err_wide);
        p_term   = fx_mul(kp, err);
        err_step = err - last_err;
        d_term   = fx_mul(kd, err_step);
        acc      = integ_acc + fx_mul(ki, err);
        integ_acc = clip_word(acc);
        // bound follows the setpoint or the error, magnitude only, capped at 0.7
        bound = fx_mul(bound_scale, by_setpoint ? sp : err);
        if (bound < 0) bound = -bound;
        if (bound > SEVEN_TENTHS) bound = 34'(SEVEN_TENTHS);
        if (integ_acc > bound) integ_acc = bound[DATA_W-1:0];
        if (integ_acc < -bound) integ_acc = -bound[DATA_W-1:0];
        total = p_term + integ_acc + d_term;
        lim   = $signed({4'b0, drive_limit});
        if (total > lim) total = lim;
        if (total < -lim) total = -lim;
        last_err = err;
        return drive_on ? total[DATA_W-1:0] : '0;
    endfunction

    function automatic logic [DATA_W-1:0] shadow_value(input t_reg_idx idx);
        case (idx)
            REG_PROP_GAIN:     return kp;
            REG_INTEG_GAIN:    return ki;
            REG_DERIV_GAIN:    return kd;
            REG_OUTPUT_LIMIT:  return {1'b0, drive_limit};
            REG_LIMIT_GAIN:    return bound_scale;
            REG_VELOCITY_MODE: return {31'b0, by_setpoint};
            default:           return {31'b0, drive_on};
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_reg_idx                 idx;
        logic signed [DATA_W-1:0] want;
        idx = t_reg_idx'(i_paddr[ADDR_W-1:2]);
        if (!i_rst_n) begin
            kp          = '0;
            ki          = '0;
            kd          = '0;
            drive_limit = '0;
            bound_scale = '0;
            by_setpoint = 1'b0;
            drive_on    = 1'b1;
            integ_acc   = '0;
            last_err    = '0;
            expected_drive.delete();
            o_pending = 0;
        end else begin
            // register writes land at the access edge
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (idx)
                    REG_PROP_GAIN:     kp          = i_pwdata;
                    REG_INTEG_GAIN:    ki          = i_pwdata;
                    REG_DERIV_GAIN:    kd          = i_pwdata;
                    REG_OUTPUT_LIMIT:  drive_limit = i_pwdata[LIMIT_W-1:0];
                    REG_LIMIT_GAIN:    bound_scale = i_pwdata;
                    REG_VELOCITY_MODE: by_setpoint = i_pwdata[0];
                    REG_ENABLE:        drive_on    = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_psel && i_penable && !i_pwrite && i_pready && idx <= REG_ENABLE) begin
                if (i_prdata !== shadow_value(idx)) begin
                    $error("prdata (reg %0d): expected %h, got %h", idx, shadow_value(idx),
                           i_prdata);
                    o_fail_count++;
                end
            end
            // compare before pushing so a stray result never meets a fresh expectation
            if (i_m_tvalid && i_m_tready) begin
                if (expected_drive.size() == 0) begin
                    $error("drive: expected no beat, got %0d", $signed(i_m_tdata));
                    o_fail_count++;
                end else begin
                    want = expected_drive.pop_front();
                    if (i_m_tdata !== want) begin
                        $error("drive: expected %0d, got %0d", want, $signed(i_m_tdata));
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_drive.push_back(next_drive(i_s_tdata[DATA_W-1:0],
                                                    i_s_tdata[2*DATA_W-1:DATA_W]));
            o_pending = expected_drive.size();
        end
    end

endmodule

[test/pid_with_adaptive_integral_limit_core_tb.sv]
// testbench top for the pid core: clock, reset, register setup, sample stimulus and verdict
module pid_with_adaptive_integral_limit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pidail_pkg::*;

    localparam int FRAC_BITS = 16;
    // register index with nothing behind it, writes there must be dropped
    localparam logic [IDX_W-1:0] UNUSED_IDX = 3'd7;
    localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_HALF    = 32'h0000_8000;
    localparam logic [DATA_W-1:0] Q_QUARTER = 32'h0000_4000;
    localparam logic [DATA_W-1:0] Q_MINUS_2 = 32'hfffe_0000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 85;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [2*DATA_W-1:0]   s_axis_tdata   = '0;  // setpoint [31:0], measured [63:32]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;         // drive [31:0]
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [ADDR_W-1:0]     paddr          = '0;
    logic [DATA_W-1:0]     pwdata         = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    int pending_beats;
    int fail_total;

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, counted down by the receiver process
    int hold_off_left  = 0;

    // current tracking target for the well-formed part of the random stimulus
    logic [DATA_W-1:0] target;

    pid_with_adaptive_integral_limit_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    pidail_drive_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_pending   (pending_beats),
        .o_fail_count(fail_total)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // apb write through setup and access phases, then back to idle so transfers never overlap
    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // read data is checked by the checker at the access edge
    task automatic reg_read(input logic [IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_back_regs();
        for (int r = REG_PROP_GAIN; r <= REG_ENABLE; r++)
            reg_read(r[IDX_W-1:0]);
    endtask

    // one sample beat, with random sender gaps ahead of it
    task automatic send_sample(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] meas);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {meas, sp};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering samples and wait until every drive beat is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0) @(posedge i_clk);
    endtask

    // sample values: extremes, full random words, mostly small magnitudes
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(11))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2:       return '0;
            3, 4:    return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // top bit is random too, only the low 31 bits should stick
    function automatic logic [DATA_W-1:0] pick_limit();
        case ($urandom_range(7))
            0:       return '0;
            1:       return {1'b0, {LIMIT_W{1'b1}}};
            2, 3:    return $urandom();
            default: return {1'($urandom_range(1)), 11'b0,
                             20'($urandom_range(0, 32'h000f_ffff))};
        endcase
    endfunction

    task automatic load_random_settings();
        logic [DATA_W-1:0] flag_word;
        reg_write(REG_PROP_GAIN, pick_gain());
        reg_write(REG_INTEG_GAIN, pick_gain());
        reg_write(REG_DERIV_GAIN, pick_gain());
        reg_write(REG_OUTPUT_LIMIT, pick_limit());
        reg_write(REG_LIMIT_GAIN, pick_gain());
        reg_write(REG_VELOCITY_MODE, $urandom());
        flag_word    = $urandom();
        flag_word[0] = ($urandom_range(9) != 0);
        reg_write(REG_ENABLE, flag_word);
        if ($urandom_range(3) == 0)
            reg_write(UNUSED_IDX, $urandom());
        read_back_regs();
    endtask

    // mostly a held target with the measurement close to it, some loose samples
    task automatic send_random_sample();
        logic [DATA_W-1:0] noise;
        if ($urandom_range(9) < 7) begin
            if ($urandom_range(9) == 0)
                target = pick_value();
            noise = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            send_sample(target, target + noise);
        end else begin
            send_sample(pick_value(), pick_value());
        end
    endtask

    initial begin
        target = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back_regs();

        // directed: unit-ish gains, widest output limit, bound from the error
        reg_write(REG_PROP_GAIN, Q_ONE);
        reg_write(REG_INTEG_GAIN, Q_HALF);
        reg_write(REG_DERIV_GAIN, Q_QUARTER);
        reg_write(REG_OUTPUT_LIMIT, {1'b0, {LIMIT_W{1'b1}}});
        reg_write(REG_LIMIT_GAIN, Q_ONE);
        reg_write(REG_VELOCITY_MODE, '0);
        reg_write(REG_ENABLE, 32'd1);
        read_back_regs();
        send_sample('0, '0);
        send_sample(Q_ONE, '0);
        send_sample(Q_ONE, '0);
        send_sample('0, Q_HALF);
        send_sample(S32_MAX, S32_MIN);   // error saturates high
        send_sample(S32_MIN, S32_MAX);   // error saturates low, widest error step
        send_sample(S32_MAX, S32_MIN);
        send_sample(-Q_ONE, '0);
        send_sample(S32_MAX, S32_MAX);
        drain();

        // directed: extreme gains, negative bound scale, bound from setpoint, tight limit
        reg_write(REG_PROP_GAIN, S32_MIN);
        reg_write(REG_INTEG_GAIN, S32_MAX);
        reg_write(REG_DERIV_GAIN, S32_MAX);
        reg_write(REG_OUTPUT_LIMIT, 32'h0003_0000);
        reg_write(REG_LIMIT_GAIN, Q_MINUS_2);
        reg_write(REG_VELOCITY_MODE, 32'd1);
        read_back_regs();
        send_sample(Q_HALF, '0);
        send_sample(Q_HALF, S32_MIN);    // integral sum overflows before the clamp
        send_sample('0, Q_ONE);          // zero setpoint gives a zero bound
        send_sample(S32_MIN, '0);
        send_sample(Q_QUARTER, 32'h0000_3000);
        send_sample(S32_MAX, '0);
        drain();

        // directed: disabled output, ignored register, then zero output limit
        reg_write(REG_ENABLE, '0);
        reg_write(UNUSED_IDX, 32'hdead_beef);
        reg_write(REG_LIMIT_GAIN, Q_ONE);
        read_back_regs();
        send_sample(32'h0002_0000, '0);
        send_sample(S32_MIN, S32_MAX);
        send_sample(32'h0000_1234, 32'h0000_4321);
        drain();
        reg_write(REG_ENABLE, 32'd1);
        reg_write(REG_OUTPUT_LIMIT, '0);
        read_back_regs();
        send_sample(32'h0005_0000, '0);
        send_sample('0, 32'h0005_0000);
        drain();

        // random phases over the idling modes, each with fresh settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            load_random_settings();
            // back pressure: receiver shut for a long stretch while samples keep coming
            if (ph == 0)
                hold_off_left = 120;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_sample();
            drain();
        end

        // let any stray beat show up before the verdict
        repeat (20) @(posedge i_clk);
        if (fail_total == 0)
            $display("pid_with_adaptive_integral_limit_core: match");
        else
            $display("pid_with_adaptive_integral_limit_core: mismatch");
        $finish;
    end

    // run limit, far beyond the slowest passing run
    initial begin
        #2_000_000;
        $display("pid_with_adaptive_integral_limit_core: mismatch");
        $finish;
    end

endmodule

[sim.f]
hdl/pidail_pkg.sv
hdl/pidail_regs.sv
hdl/pidail_qsat.sv
hdl/pidail_datapath.sv
hdl/pid_with_adaptive_integral_limit_core.sv
hdl/pidail_checker.sv
test/pidail_drive_checker.sv
test/pid_with_adaptive_integral_limit_core_tb.sv
